// ===== rtl/kcl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kcl_pkg: shared types and constants of the keypad code lock
// Mode and event codes, register indexes, configuration and result bundles.
// ----------------------------------------------------------------------------
package kcl_pkg;

  localparam int MAX_DIGITS = 16;
  localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);
  localparam int CNT_W      = 5;
  localparam int CFG_IDX_W  = 3;

  localparam logic [3:0]  KEY_ENTER        = 4'd15;
  localparam logic [3:0]  WRONG_MAX        = 4'd15;
  localparam logic [15:0] UNITS_MAX        = 16'hFFFF;

  localparam logic [63:0] RST_STORED_CODE  = 64'h0000_0000_8765_4321;
  localparam logic [3:0]  RST_CODE_LENGTH  = 4'd8;
  localparam logic [3:0]  RST_ATTEMPT_LIM  = 4'd3;
  localparam logic [7:0]  RST_TICKS_UNIT   = 8'd100;
  localparam logic [7:0]  RST_LOCKOUT_UNIT = 8'd3;
  localparam logic [7:0]  RST_OPEN_UNITS   = 8'd10;
  localparam logic [3:0]  RST_FRAME_BYTES  = 4'd9;

  typedef enum logic [1:0] {
    MODE_ENTRY   = 2'd0,
    MODE_LOCKOUT = 2'd1,
    MODE_OPEN    = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CMD_KEY    = 2'd0,
    CMD_SERIAL = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    EVT_NONE        = 3'd0,
    EVT_DIGIT       = 3'd1,
    EVT_RIGHT       = 3'd2,
    EVT_WRONG       = 3'd3,
    EVT_LOCKOUT     = 3'd4,
    EVT_RELOCKED    = 3'd5,
    EVT_LOCKOUT_END = 3'd6
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STORED_CODE   = 3'd0,
    REG_CODE_LENGTH   = 3'd1,
    REG_ATTEMPT_LIMIT = 3'd2,
    REG_TICKS_UNIT    = 3'd3,
    REG_LOCKOUT_UNITS = 3'd4,
    REG_OPEN_UNITS    = 3'd5,
    REG_FRAME_BYTES   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] stored_code;
    logic [3:0]  code_length;
    logic [3:0]  attempt_limit;
    logic [7:0]  ticks_per_unit;
    logic [7:0]  lockout_units;
    logic [7:0]  open_units;
    logic [3:0]  frame_bytes;
  } cfg_t;

  typedef struct packed {
    logic             lock_open;
    mode_t            mode_now;
    event_t           event_code;
    logic [3:0]       attempts_used;
    logic [CNT_W-1:0] digits_entered;
    logic             report_due;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/kcl_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kcl_cfg_regs: configuration register file
// Takes one register write per cycle and presents all settings as a bundle.
// ----------------------------------------------------------------------------
module kcl_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [kcl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]                   cfg_data,
  output kcl_pkg::cfg_t                      cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stored_code    <= kcl_pkg::RST_STORED_CODE;
      cfg.code_length    <= kcl_pkg::RST_CODE_LENGTH;
      cfg.attempt_limit  <= kcl_pkg::RST_ATTEMPT_LIM;
      cfg.ticks_per_unit <= kcl_pkg::RST_TICKS_UNIT;
      cfg.lockout_units  <= kcl_pkg::RST_LOCKOUT_UNIT;
      cfg.open_units     <= kcl_pkg::RST_OPEN_UNITS;
      cfg.frame_bytes    <= kcl_pkg::RST_FRAME_BYTES;
    end else if (cfg_valid && cfg_ready) begin
      unique case (kcl_pkg::reg_idx_t'(cfg_index))
        kcl_pkg::REG_STORED_CODE:   cfg.stored_code    <= cfg_data;
        kcl_pkg::REG_CODE_LENGTH:   cfg.code_length    <= cfg_data[3:0];
        kcl_pkg::REG_ATTEMPT_LIMIT: cfg.attempt_limit  <= cfg_data[3:0];
        kcl_pkg::REG_TICKS_UNIT:    cfg.ticks_per_unit <= cfg_data[7:0];
        kcl_pkg::REG_LOCKOUT_UNITS: cfg.lockout_units  <= cfg_data[7:0];
        kcl_pkg::REG_OPEN_UNITS:    cfg.open_units     <= cfg_data[7:0];
        kcl_pkg::REG_FRAME_BYTES:   cfg.frame_bytes    <= cfg_data[3:0];
        default: ;  // drop writes beyond the list
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/kcl_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kcl_core: lock state and single-pass update
// Holds mode, counters and the digit buffer; computes one word's update.
// ----------------------------------------------------------------------------
module kcl_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       adv,
  input  wire logic [1:0] cmd,
  input  wire logic [3:0] key,
  input  kcl_pkg::cfg_t   cfg,
  output kcl_pkg::result_t res
);

  localparam int IW = kcl_pkg::DIG_IDX_W;
  localparam int CW = kcl_pkg::CNT_W;

  kcl_pkg::mode_t  mode, mode_next;
  logic [CW-1:0]   digit_count, digit_count_next;
  logic [3:0]      wrong_count, wrong_count_next;
  logic            open_pending, open_pending_next;
  logic [7:0]      fine_ticks, fine_ticks_next;
  logic [15:0]     coarse_units, coarse_units_next;
  logic [3:0]      serial_count, serial_count_next;
  logic [3:0]      digit_store [kcl_pkg::MAX_DIGITS];

  kcl_pkg::event_t evt;
  logic            report;
  logic            store_we;
  logic            code_ok;
  logic [CW-1:0]   cnt_inc;
  logic [3:0]      wrong_inc;
  logic [3:0]      serial_inc;
  logic [7:0]      fine_inc;
  logic [15:0]     units;
  logic            pend;

  // Compare the digits buffered so far with the stored code; the length of
  // the entry is the current count since the closing key is not compared.
  always_comb begin
    code_ok = (digit_count == {1'b0, cfg.code_length});
    for (int j = 0; j < kcl_pkg::MAX_DIGITS; j++) begin
      if ((CW'(j) < digit_count) && (digit_store[j] != cfg.stored_code[4*j +: 4])) begin
        code_ok = 1'b0;
      end
    end
  end

  // Next state
  always_comb begin
    mode_next         = mode;
    digit_count_next  = digit_count;
    wrong_count_next  = wrong_count;
    fine_ticks_next   = fine_ticks;
    coarse_units_next = coarse_units;
    serial_count_next = serial_count;
    pend              = open_pending;
    evt               = kcl_pkg::EVT_NONE;
    report            = 1'b0;
    store_we          = 1'b0;
    cnt_inc           = digit_count + CW'(1);
    wrong_inc         = (wrong_count < kcl_pkg::WRONG_MAX) ? wrong_count + 4'd1 : wrong_count;
    serial_inc        = serial_count + 4'd1;
    fine_inc          = fine_ticks + 8'd1;
    units             = coarse_units;

    case (cmd)
      kcl_pkg::CMD_KEY: begin
        if (mode == kcl_pkg::MODE_ENTRY) begin
          store_we = 1'b1;
          if (key != kcl_pkg::KEY_ENTER && cnt_inc < CW'(kcl_pkg::MAX_DIGITS)) begin
            digit_count_next = cnt_inc;
            evt              = kcl_pkg::EVT_DIGIT;
          end else begin
            digit_count_next = '0;
            if (code_ok) begin
              wrong_count_next = '0;
              pend             = 1'b1;
              evt              = kcl_pkg::EVT_RIGHT;
            end else if (wrong_inc >= cfg.attempt_limit) begin
              wrong_count_next  = '0;
              mode_next         = kcl_pkg::MODE_LOCKOUT;
              coarse_units_next = '0;
              evt               = kcl_pkg::EVT_LOCKOUT;
            end else begin
              wrong_count_next = wrong_inc;
              evt              = kcl_pkg::EVT_WRONG;
            end
          end
        end
      end
      kcl_pkg::CMD_SERIAL: begin
        if (serial_inc >= cfg.frame_bytes) begin
          serial_count_next = '0;
          pend              = 1'b1;
        end else begin
          serial_count_next = serial_inc;
        end
      end
      kcl_pkg::CMD_TICK: begin
        if (fine_inc >= cfg.ticks_per_unit) begin
          fine_ticks_next = '0;
          report          = 1'b1;
          if (coarse_units != kcl_pkg::UNITS_MAX) begin
            units = coarse_units + 16'd1;
          end
        end else begin
          fine_ticks_next = fine_inc;
        end
        if (mode == kcl_pkg::MODE_LOCKOUT && units >= {8'd0, cfg.lockout_units}) begin
          mode_next = kcl_pkg::MODE_ENTRY;
          units     = '0;
          evt       = kcl_pkg::EVT_LOCKOUT_END;
        end else if (mode == kcl_pkg::MODE_OPEN && units >= {8'd0, cfg.open_units}) begin
          mode_next = kcl_pkg::MODE_ENTRY;
          evt       = kcl_pkg::EVT_RELOCKED;
        end
        coarse_units_next = units;
      end
      default: ;
    endcase

    // Serve a pending open request as soon as the lock is not already open.
    open_pending_next = pend;
    if (pend && mode_next != kcl_pkg::MODE_OPEN) begin
      mode_next         = kcl_pkg::MODE_OPEN;
      coarse_units_next = '0;
      open_pending_next = 1'b0;
    end
  end

  // Outputs
  always_comb begin
    res.lock_open      = (mode_next == kcl_pkg::MODE_OPEN);
    res.mode_now       = mode_next;
    res.event_code     = evt;
    res.attempts_used  = wrong_count_next;
    res.digits_entered = digit_count_next;
    res.report_due     = report;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= kcl_pkg::MODE_ENTRY;
      digit_count  <= '0;
      wrong_count  <= '0;
      open_pending <= 1'b0;
      fine_ticks   <= '0;
      coarse_units <= '0;
      serial_count <= '0;
    end else if (adv) begin
      mode         <= mode_next;
      digit_count  <= digit_count_next;
      wrong_count  <= wrong_count_next;
      open_pending <= open_pending_next;
      fine_ticks   <= fine_ticks_next;
      coarse_units <= coarse_units_next;
      serial_count <= serial_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && store_we) begin
      digit_store[digit_count[IW-1:0]] <= key;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/keypad_code_lock_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_code_lock_controller: keypad combination lock, top level
// Input register, single-pass lock update and result register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid / item_stall) carries one event word: a key
//   press, a received serial byte or a timer tick. Every accepted word
//   yields exactly one result word on the result channel (result_valid /
//   result_stall) with the lock status, mode, event code, attempt count,
//   buffered digit count and the coarse-unit report pulse.
//   Each accepted word is registered in the input register and passes
//   through the update logic into the result register once that register
//   is not blocked by a stalled result word.
//   Throughput is one word per cycle while the receiver does not stall; the
//   digit compare, counter updates and mode logic are all combinational
//   between the two registers.
//   When the receiver stalls, the result register holds its word and the
//   input register keeps accepting until it too is full; item_stall then
//   rises, so no word is lost or repeated.
//   The configuration channel (cfg_valid / cfg_ready, always ready) writes one
//   register per cycle; write only while no word is in flight.
//   Reset (rst, synchronous) restores the default code and timings, puts the
//   lock in entry mode, closed, with all counters cleared. The digit buffer
//   is not cleared; only digits of the current entry are ever compared.
// ----------------------------------------------------------------------------
module keypad_code_lock_controller (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // event words in
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic [1:0]                    command,
  input  wire logic [3:0]                    key_value,
  // result words out
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic                               lock_open,
  output logic [1:0]                         mode_now,
  output logic [2:0]                         event_code,
  output logic [3:0]                         attempts_used,
  output logic [kcl_pkg::CNT_W-1:0]          digits_entered,
  output logic                               report_due,
  // configuration writes
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [kcl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]                   cfg_data
);

  kcl_pkg::cfg_t    cfg;
  kcl_pkg::result_t core_res;
  kcl_pkg::result_t res;

  logic       in_full;
  logic [1:0] in_cmd;
  logic [3:0] in_key;
  logic       out_blocked;
  logic       adv;
  logic       accept;

  // The result register is blocked only while it holds a word that is stalled.
  assign out_blocked = result_valid && result_stall;
  assign adv         = in_full && !out_blocked;
  assign item_stall  = in_full && out_blocked;
  assign accept      = item_valid && !item_stall;

  kcl_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kcl_core u_core (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .cmd (in_cmd),
    .key (in_key),
    .cfg (cfg),
    .res (core_res)
  );

  // Input register: load on accept, drop once the word moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (adv) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_cmd <= command;
      in_key <= key_value;
    end
  end

  // Result register: hold while stalled, refill whenever a word advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= core_res;
    end
  end

  assign lock_open      = res.lock_open;
  assign mode_now       = res.mode_now;
  assign event_code     = res.event_code;
  assign attempts_used  = res.attempts_used;
  assign digits_entered = res.digits_entered;
  assign report_due     = res.report_due;

endmodule
`default_nettype wire

// ===== rtl/kcl_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kcl_checker: port-level checks of the keypad code lock
// Watches the result channel for consistency of lock status and events.
// ----------------------------------------------------------------------------
module kcl_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       result_valid,
  input wire logic       result_stall,
  input wire logic       lock_open,
  input wire logic [1:0] mode_now,
  input wire logic [2:0] event_code,
  input wire logic [3:0] attempts_used
);

  // The lock is released exactly in open mode.
  a_open_mode: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (lock_open == (mode_now == kcl_pkg::MODE_OPEN)))
    else $error("lock_open disagrees with mode_now");

  // A right code clears the attempt count and opens the lock.
  a_right_opens: assert property (@(posedge clk) disable iff (rst)
    (result_valid && event_code == kcl_pkg::EVT_RIGHT) |-> (lock_open && attempts_used == 4'd0))
    else $error("right code did not open with a clear count");

  // Entering lockout clears the attempt count and leaves the lock closed or
  // reopened by a pending request.
  a_lockout: assert property (@(posedge clk) disable iff (rst)
    (result_valid && event_code == kcl_pkg::EVT_LOCKOUT) |->
      (attempts_used == 4'd0 &&
       (mode_now == kcl_pkg::MODE_LOCKOUT || mode_now == kcl_pkg::MODE_OPEN)))
    else $error("lockout event with wrong state");

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(event_code) && $stable(mode_now)))
    else $error("stalled result word changed");

endmodule

bind keypad_code_lock_controller kcl_checker u_kcl_checker (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .lock_open     (lock_open),
  .mode_now      (mode_now),
  .event_code    (event_code),
  .attempts_used (attempts_used)
);
`default_nettype wire
